// ===== sv/rde_pkg.sv =====
// Shared types and constants for the radix digit emitter.
`timescale 1ns / 1ps
`default_nettype none
package rde_pkg;

  // Alphabet limits and fixed character codes
  localparam int unsigned MaxSymbols = 16;
  localparam logic [7:0]  CharPlus   = 8'h2B;
  localparam logic [7:0]  CharMinus  = 8'h2D;

  // Magnitude width, digit store depth and divider pacing
  localparam int unsigned MagW          = 32;
  localparam int unsigned MaxDigits     = 32;
  localparam int unsigned DigitIdxW     = $clog2(MaxDigits);
  localparam int unsigned BitsPerCycle  = 8;
  localparam int unsigned StepsPerDigit = MagW / BitsPerCycle;
  localparam int unsigned StepCntW      = $clog2(StepsPerDigit);

  // Configuration register indexes
  localparam logic [1:0] RegSymbolCount = 2'd0;
  localparam logic [1:0] RegSymbolsLow  = 2'd1;
  localparam logic [1:0] RegSymbolsHigh = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StSign,
    StEmit,
    StError
  } state_e;

  // Alphabet as seen by the datapath and controller
  typedef struct packed {
    logic [4:0]                   base;
    logic [MaxSymbols-1:0][7:0]   symbols;
    logic                         bad;
  } alpha_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic nd_full;
    logic neg;
    logic ptr_zero;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/rde_cfg.sv =====
// Configuration registers and alphabet validity check.
`timescale 1ns / 1ps
`default_nettype none
module rde_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_data_i,
  output rde_pkg::alpha_t    alpha_o
);
  import rde_pkg::*;

  logic [4:0]  count_q;
  logic [63:0] sym_lo_q, sym_hi_q;
  logic [MaxSymbols-1:0][7:0] syms;
  logic bad;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 5'd2;
      sym_lo_q <= 64'h3130;
      sym_hi_q <= 64'h0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSymbolCount: count_q  <= cfg_data_i[4:0];
        RegSymbolsLow:  sym_lo_q <= cfg_data_i;
        RegSymbolsHigh: sym_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign syms = {sym_hi_q, sym_lo_q};

  // Validity: count range, no sign symbols, no repeats among used symbols
  always_comb begin
    bad = (count_q < 5'd2) || (count_q > 5'(MaxSymbols));
    for (int i = 0; i < MaxSymbols; i++) begin
      if (5'(i) < count_q) begin
        if (syms[i] == CharPlus || syms[i] == CharMinus) bad = 1'b1;
        for (int j = i + 1; j < MaxSymbols; j++) begin
          if (5'(j) < count_q && syms[i] == syms[j]) bad = 1'b1;
        end
      end
    end
  end

  assign alpha_o.base    = count_q;
  assign alpha_o.symbols = syms;
  assign alpha_o.bad     = bad;

endmodule
`default_nettype wire

// ===== sv/rde_ctrl.sv =====
// Sequencing state machine for divide and emit phases.
`timescale 1ns / 1ps
`default_nettype none
module rde_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        alpha_bad_i,
  input  rde_pkg::sts_t    sts_i,
  output rde_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import rde_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = alpha_bad_i ? StError : StDivide;
      end
      StDivide: begin
        if (sts_i.digit_done && (sts_i.quot_zero || sts_i.nd_full)) begin
          state_d = sts_i.neg ? StSign : StEmit;
        end
      end
      StSign:  state_d = StEmit;
      StEmit: begin
        if (sts_i.ptr_zero) state_d = StIdle;
      end
      StError: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle:   cmd_o.load       = start;
      StDivide: cmd_o.div_step   = 1'b1;
      StSign:   cmd_o.emit_sign  = 1'b1;
      StEmit:   cmd_o.emit_digit = 1'b1;
      StError:  cmd_o.emit_err   = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  assign busy = (state_q != StIdle);

endmodule
`default_nettype wire

// ===== sv/rde_dp.sv =====
// Datapath: shared radix divider, digit store and output register.
`timescale 1ns / 1ps
`default_nettype none
module rde_dp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] value_i,
  input  rde_pkg::alpha_t  alpha_i,
  input  rde_pkg::cmd_t    cmd_i,
  output rde_pkg::sts_t    sts_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             is_last_o,
  output logic             bad_alphabet_o
);
  import rde_pkg::*;

  logic [MagW-1:0]      quot_q, quot_d;
  logic [4:0]           rem_q, rem_d;
  logic [StepCntW-1:0]  step_q;
  logic [DigitIdxW-1:0] nd_q, ptr_q;
  logic                 neg_q;
  logic [3:0]           digits_q [MaxDigits];

  logic       valid_q, last_q, err_q;
  logic [7:0] char_q;

  // Restoring division, BitsPerCycle quotient bits per cycle
  always_comb begin
    logic [4:0] t;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int k = 0; k < BitsPerCycle; k++) begin
      t = {rem_d[3:0], quot_d[MagW-1]};
      if (t >= alpha_i.base) begin
        rem_d  = t - alpha_i.base;
        quot_d = {quot_d[MagW-2:0], 1'b1};
      end else begin
        rem_d  = t;
        quot_d = {quot_d[MagW-2:0], 1'b0};
      end
    end
  end

  // Divider state and digit bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      nd_q   <= '0;
      ptr_q  <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      step_q <= '0;
      nd_q   <= '0;
      neg_q  <= value_i[31];
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
      if (sts_o.digit_done) begin
        nd_q  <= nd_q + 1'b1;
        ptr_q <= nd_q;
      end
    end else if (cmd_i.emit_digit) begin
      ptr_q <= ptr_q - 1'b1;
    end
  end

  // Quotient, remainder and digit store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q <= value_i[31] ? (~value_i + 32'd1) : value_i;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      if (sts_o.digit_done) begin
        rem_q          <= '0;
        digits_q[nd_q] <= rem_d[3:0];
      end else begin
        rem_q <= rem_d;
      end
    end
  end

  assign sts_o.digit_done = (step_q == StepCntW'(StepsPerDigit - 1));
  assign sts_o.quot_zero  = (quot_d == '0);
  assign sts_o.nd_full    = (nd_q == DigitIdxW'(MaxDigits - 1));
  assign sts_o.neg        = neg_q;
  assign sts_o.ptr_zero   = (ptr_q == '0);

  // Result register: one strobe per emitted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_sign | cmd_i.emit_digit | cmd_i.emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CharMinus;
      last_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= alpha_i.symbols[digits_q[ptr_q]];
      last_q <= (ptr_q == '0);
      err_q  <= 1'b0;
    end else if (cmd_i.emit_err) begin
      char_q <= 8'h00;
      last_q <= 1'b1;
      err_q  <= 1'b1;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_char_o     = char_q;
  assign is_last_o      = last_q;
  assign bad_alphabet_o = err_q;

endmodule
`default_nettype wire

// ===== sv/radix_digit_emitter_core.sv =====
// Top level: signed integer to text in a configurable base and alphabet.
// Flow: the divider works out each digit (8 quotient bits per cycle, 32-bit
// magnitude), then the characters go out back to back, the sign first when
// the value is negative; a value has 1 to 32 digits. A new value is taken
// only while idle; an invalid alphabet gives a single error character.
// Results cannot be stalled. Reset: idle, base 2 alphabet "01".
`timescale 1ns / 1ps
`default_nettype none
module radix_digit_emitter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             is_last_o,
  output logic             bad_alphabet_o
);
  import rde_pkg::*;

  alpha_t alpha;
  cmd_t   cmd;
  sts_t   sts;

  rde_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .alpha_o    (alpha)
  );

  rde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .alpha_bad_i (alpha.bad),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  rde_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .alpha_i        (alpha),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_char_o     (out_char_o),
    .is_last_o      (is_last_o),
    .bad_alphabet_o (bad_alphabet_o)
  );

endmodule
`default_nettype wire

// ===== sv/rde_chk.sv =====
// Port-level checker for the emitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rde_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid_o,
  input wire logic [7:0] out_char_o,
  input wire logic       is_last_o,
  input wire logic       bad_alphabet_o
);

  // Accepted request keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // Error result is a single, final, zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_alphabet_o |-> is_last_o && out_char_o == 8'h00)
    else $error("malformed error result");

  // Characters of one value come back to back until the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |=> out_valid_o)
    else $error("gap inside a value's characters");

  // Going idle coincides with the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_o && is_last_o)
    else $error("block went idle without a final character");

endmodule

bind radix_digit_emitter_core rde_chk u_rde_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .out_valid_o    (out_valid_o),
  .out_char_o     (out_char_o),
  .is_last_o      (is_last_o),
  .bad_alphabet_o (bad_alphabet_o)
);
`default_nettype wire

// ===== test/radix_digit_emitter_core_tb.sv =====
// Testbench for radix_digit_emitter_core: directed and random values over many alphabets.
`timescale 1ns / 1ps
module radix_digit_emitter_core_tb;
  import rde_pkg::*;

  localparam int unsigned StallLimit = 4000;

  // One emitted character as the block should present it
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_char_t;

  // Tracks the alphabet, spells each accepted value and checks the emitted text
  class text_scoreboard;
    logic [4:0]  base;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;
    text_char_t  pending_chars[$];
    int unsigned fail_count;

    function new();
      base       = 5'd2;
      sym_lo     = 64'h3130;
      sym_hi     = '0;
      fail_count = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        RegSymbolCount: base = data[4:0];
        RegSymbolsLow:  sym_lo = data;
        RegSymbolsHigh: sym_hi = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] symbol(int unsigned idx);
      int unsigned k;
      k = idx % 16;
      return (k < 8) ? sym_lo[8*k +: 8] : sym_hi[8*(k-8) +: 8];
    endfunction

    // Base within 2..16, no sign characters, no repeats among the used symbols
    function bit alphabet_valid();
      if (base < 2 || base > MaxSymbols) return 1'b0;
      for (int unsigned i = 0; i < base; i++) begin
        if (symbol(i) == CharPlus || symbol(i) == CharMinus) return 1'b0;
        for (int unsigned j = i + 1; j < base; j++)
          if (symbol(j) == symbol(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Queue the characters that one value should produce
    function void spell_value(logic [31:0] v);
      logic [31:0] mag;
      logic [7:0]  digits[$];
      if (!alphabet_valid()) begin
        pending_chars.push_back('{ch: 8'h00, last: 1'b1, bad: 1'b1});
        return;
      end
      // two's complement negate in 32 bits also gives the right magnitude of the minimum
      mag = v[31] ? (~v + 32'd1) : v;
      do begin
        digits.push_front(symbol(mag % 32'(base)));
        mag = mag / 32'(base);
      end while (mag != 0);
      if (v[31]) pending_chars.push_back('{ch: CharMinus, last: 1'b0, bad: 1'b0});
      foreach (digits[i])
        pending_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1), bad: 1'b0});
    endfunction

    function void note_request(logic [31:0] v);
      spell_value(v);
    endfunction

    function void check_result(logic [7:0] ch, logic last, logic bad);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: out_char=%02h is_last=%0b bad_alphabet=%0b", ch, last, bad);
        fail_count++;
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        $error("out_char: expected %02h, got %02h", want.ch, ch);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("is_last: expected %0b, got %0b", want.last, last);
        fail_count++;
      end
      if (bad !== want.bad) begin
        $error("bad_alphabet: expected %0b, got %0b", want.bad, bad);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] value_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        out_valid_o;
  logic [7:0]  out_char_o;
  logic        is_last_o;
  logic        bad_alphabet_o;

  text_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int unsigned    quiet_cycles = 0;

  radix_digit_emitter_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_char_o     (out_char_o),
    .is_last_o      (is_last_o),
    .bad_alphabet_o (bad_alphabet_o)
  );

  always #6 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(out_valid_o)) begin
        $error("out_valid_o is unknown");
        sb.fail_count++;
      end else if (out_valid_o) begin
        sb.check_result(out_char_o, is_last_o, bad_alphabet_o);
      end
    end
  end

  // Watchdog: too long without a request or a result taken
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request, with random holes in start while idling is on
  task automatic push_value(input logic [31:0] v);
    bit taken;
    bit go;
    taken = 1'b0;
    value_i <= v;
    while (!taken) begin
      go = !idle_on || ($urandom_range(0, 99) >= 6);
      start <= go;
      @(posedge clk_i);
      taken = start && !busy;
    end
    sb.note_request(v);
  endtask

  // Hold off until all characters are out and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
  endtask

  task automatic set_alphabet(input logic [63:0] cnt_word, input logic [63:0] lo,
                              input logic [63:0] hi);
    drain();
    cfg_write(RegSymbolCount, cnt_word);
    cfg_write(RegSymbolsLow, lo);
    cfg_write(RegSymbolsHigh, hi);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly valid alphabets with distinct symbols; one in four broken on purpose
  function automatic void random_alphabet(output logic [63:0] cnt_word,
                                          output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0]   sym[16];
    bit   [255:0] used;
    logic [7:0]   b;
    int unsigned  cnt, i, j;
    case ($urandom_range(0, 3))
      0: cnt = 2;
      1: cnt = 16;
      default: cnt = $urandom_range(2, 16);
    endcase
    used = '0;
    used[CharPlus]  = 1'b1;
    used[CharMinus] = 1'b1;
    for (i = 0; i < 16; i++) begin
      if (i < cnt) begin
        do b = 8'($urandom_range(0, 255)); while (used[b]);
        used[b] = 1'b1;
        sym[i]  = b;
      end else begin
        sym[i] = 8'($urandom);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: cnt = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        1: sym[$urandom_range(0, cnt - 1)] = CharPlus;
        2: sym[$urandom_range(0, cnt - 1)] = CharMinus;
        default: begin
          i = $urandom_range(0, cnt - 2);
          j = $urandom_range(i + 1, cnt - 1);
          sym[j] = sym[i];
        end
      endcase
    end
    // upper bits of the count word are don't-care for the register
    cnt_word      = {$urandom, $urandom};
    cnt_word[4:0] = 5'(cnt);
    for (i = 0; i < 16; i++) begin
      if (i < 8) lo[8*i +: 8] = sym[i];
      else hi[8*(i-8) +: 8] = sym[i];
    end
  endfunction

  // Extremes, small values, values around powers of the base, and full-range noise
  function automatic logic [31:0] random_value(int unsigned b);
    logic [31:0] p;
    int unsigned k;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: p = 32'd0;
          1: p = 32'd1;
          2: p = '1;
          3: p = 32'h7FFF_FFFF;
          default: p = 32'h8000_0000;
        endcase
      end
      1, 2: begin
        p = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) p = ~p + 32'd1;
      end
      3: begin
        p = 32'd1;
        if (b >= 2) begin
          k = $urandom_range(1, 31);
          while (k > 0 && p <= 32'h7FFF_FFFF / b) begin
            p = p * b;
            k--;
          end
        end
        p = p - 32'd1 + $urandom_range(0, 2);
        if ($urandom_range(0, 1)) p = ~p + 32'd1;
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  localparam logic [63:0] HexLo = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HexHi = 64'h4645_4443_4241_3938;

  initial begin
    logic [63:0] cw, lo, hi;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    value_i    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= RegSymbolCount;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset alphabet: binary "01"
    push_value(32'd0);
    push_value(32'd1);
    push_value('1);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);

    // Full hex alphabet, uses every symbol slot
    set_alphabet(64'd16, HexLo, HexHi);
    push_value(32'd0);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(32'hDEAD_BEEF);

    // Base 3 with a zero byte symbol; unused slots hold sign bytes and must be ignored
    set_alphabet(64'd3, 64'h2B2B_2B2B_2B61_FF00, 64'h2D2D_2D2D_2D2D_2D2D);
    push_value(32'd0);
    push_value(32'hFFFF_FFF7);
    push_value(32'h8000_0000);

    // Broken alphabets: count too small, too large, sign symbols, repeated symbol
    set_alphabet(64'd0, HexLo, HexHi);
    push_value($urandom);
    set_alphabet(64'd1, HexLo, HexHi);
    push_value($urandom);
    set_alphabet(64'd17, HexLo, HexHi);
    push_value($urandom);
    set_alphabet(64'hFFFF_FFFF_FFFF_FFFF, HexLo, HexHi);
    push_value($urandom);
    set_alphabet(64'd16, 64'h3736_2B34_3332_3130, HexHi);
    push_value($urandom);
    set_alphabet(64'd16, HexLo, 64'h2D45_4443_4241_3938);
    push_value($urandom);
    set_alphabet(64'd10, HexLo, 64'h4645_4443_4241_3038);
    push_value($urandom);

    // Random alphabets and values; two back-to-back phases run without idling
    for (int unsigned ph = 0; ph < 11; ph++) begin
      random_alphabet(cw, lo, hi);
      idle_on = !(ph == 5 || ph == 6);
      set_alphabet(cw, lo, hi);
      for (int unsigned n = 0; n < 30; n++) begin
        if (ph == 2 && n == 15) drain();
        push_value(random_value(sb.base));
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rde_pkg.sv
sv/rde_cfg.sv
sv/rde_ctrl.sv
sv/rde_dp.sv
sv/radix_digit_emitter_core.sv
sv/rde_chk.sv
test/radix_digit_emitter_core_tb.sv
